>>> rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types and constants for the trial-division prime test
// Widths of the value path, controller states and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   // Width of the tested value (two's complement)
   localparam int VALUE_WIDTH = 32;
   // Magnitude of a non-negative value: sign bit dropped
   localparam int MAG_WIDTH   = VALUE_WIDTH - 1;
   // Trial divisor: a little above the square root of the largest magnitude
   localparam int DIV_WIDTH   = (VALUE_WIDTH + 1) / 2 + 1;
   // Running square of the divisor
   localparam int SQ_WIDTH    = VALUE_WIDTH + 1;
   // Bit counter of the remainder unit
   localparam int CNT_WIDTH   = $clog2(MAG_WIDTH);

   // First odd divisor and its square
   localparam logic [DIV_WIDTH-1:0] FIRST_DIVISOR = DIV_WIDTH'(3);
   localparam logic [SQ_WIDTH-1:0]  FIRST_SQUARE  = SQ_WIDTH'(9);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BOUND,
      ST_DIVIDE,
      ST_TEST
   } tdpt_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;       // capture a new request value
      logic div_start;  // clear remainder, reload dividend shifter
      logic div_step;   // one restoring remainder step
      logic next_div;   // advance to the next odd divisor
   } tdpt_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic negative;
      logic le_one;
      logic lt_four;
      logic even;
      logic sq_gt_n;
      logic div_last;
      logic rem_zero;
   } tdpt_stat_type;

endpackage

>>> rtl/tdpt_datapath.sv
// ----------------------------------------------------------------------------
// tdpt_datapath: value register, divisor and square, remainder unit
// Holds the magnitude under test, steps odd divisors with an incremental
// square, and computes n mod d one bit per cycle with a restoring unit.
// ----------------------------------------------------------------------------
module tdpt_datapath (
   input  logic                                 clock,
   input  logic signed [tdpt_pkg::VALUE_WIDTH-1:0] req_value,
   input  tdpt_pkg::tdpt_cmd_type               cmd,
   output tdpt_pkg::tdpt_stat_type              stat
);

   logic                              sign_ff;
   logic [tdpt_pkg::MAG_WIDTH-1:0]    n_ff;
   logic [tdpt_pkg::DIV_WIDTH-1:0]    d_ff,   d_in;
   logic [tdpt_pkg::SQ_WIDTH-1:0]     sq_ff,  sq_in;
   logic [tdpt_pkg::DIV_WIDTH-1:0]    rem_ff, rem_in;
   logic [tdpt_pkg::MAG_WIDTH-1:0]    sh_ff,  sh_in;
   logic [tdpt_pkg::CNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic [tdpt_pkg::DIV_WIDTH:0]      trial;
   logic [tdpt_pkg::SQ_WIDTH-1:0]     n_wide;

   // Capture the request value
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sign_ff <= req_value[tdpt_pkg::VALUE_WIDTH-1];
         n_ff    <= req_value[tdpt_pkg::MAG_WIDTH-1:0];
      end
   end

   // Next divisor and its square: (d+2)^2 = d^2 + 4d + 4
   always_comb begin
      d_in  = d_ff;
      sq_in = sq_ff;
      if (cmd.load) begin
         d_in  = tdpt_pkg::FIRST_DIVISOR;
         sq_in = tdpt_pkg::FIRST_SQUARE;
      end else if (cmd.next_div) begin
         d_in  = d_ff + tdpt_pkg::DIV_WIDTH'(2);
         sq_in = sq_ff + tdpt_pkg::SQ_WIDTH'({d_ff, 2'b00}) + tdpt_pkg::SQ_WIDTH'(4);
      end
   end

   // Restoring remainder step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, sh_ff[tdpt_pkg::MAG_WIDTH-1]};

   always_comb begin
      rem_in = rem_ff;
      sh_in  = sh_ff;
      cnt_in = cnt_ff;
      if (cmd.div_start) begin
         rem_in = '0;
         sh_in  = n_ff;
         cnt_in = tdpt_pkg::CNT_WIDTH'(tdpt_pkg::MAG_WIDTH - 1);
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, d_ff}) begin
            rem_in = tdpt_pkg::DIV_WIDTH'(trial - {1'b0, d_ff});
         end else begin
            rem_in = tdpt_pkg::DIV_WIDTH'(trial);
         end
         sh_in  = {sh_ff[tdpt_pkg::MAG_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - tdpt_pkg::CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      d_ff   <= d_in;
      sq_ff  <= sq_in;
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      cnt_ff <= cnt_in;
   end

   // Status toward the controller
   assign n_wide = {{(tdpt_pkg::SQ_WIDTH - tdpt_pkg::MAG_WIDTH){1'b0}}, n_ff};

   always_comb begin
      stat.negative = sign_ff;
      stat.le_one   = (n_ff <= tdpt_pkg::MAG_WIDTH'(1));
      stat.lt_four  = (n_ff <  tdpt_pkg::MAG_WIDTH'(4));
      stat.even     = ~n_ff[0];
      stat.sq_gt_n  = (sq_ff > n_wide);
      stat.div_last = (cnt_ff == '0);
      stat.rem_zero = (rem_ff == '0);
   end

endmodule

>>> rtl/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl: sequencing state machine for the prime test
// Screens negative, small and even values, then loops bound check, remainder and
// divisor step until a factor is found or the square passes the value.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  tdpt_pkg::tdpt_stat_type stat,
   output tdpt_pkg::tdpt_cmd_type  cmd,
   output logic                    rsp_valid,
   output logic                    rsp_is_prime
);

   tdpt_pkg::tdpt_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_prime_ff, rsp_prime_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            if (start) state_in = tdpt_pkg::ST_CHECK;
         end
         tdpt_pkg::ST_CHECK: begin
            if (stat.negative || stat.le_one || stat.lt_four || stat.even) begin
               state_in = tdpt_pkg::ST_IDLE;
            end else begin
               state_in = tdpt_pkg::ST_BOUND;
            end
         end
         tdpt_pkg::ST_BOUND: begin
            if (stat.sq_gt_n) state_in = tdpt_pkg::ST_IDLE;
            else              state_in = tdpt_pkg::ST_DIVIDE;
         end
         tdpt_pkg::ST_DIVIDE: begin
            if (stat.div_last) state_in = tdpt_pkg::ST_TEST;
         end
         tdpt_pkg::ST_TEST: begin
            if (stat.rem_zero) state_in = tdpt_pkg::ST_IDLE;
            else               state_in = tdpt_pkg::ST_BOUND;
         end
         default: state_in = tdpt_pkg::ST_IDLE;
      endcase
   end

   // Commands and result
   always_comb begin
      cmd          = '0;
      rsp_valid_in = 1'b0;
      rsp_prime_in = rsp_prime_ff;
      unique case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            cmd.load = start;
         end
         tdpt_pkg::ST_CHECK: begin
            priority if (stat.negative || stat.le_one) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = 1'b0;
            end else if (stat.lt_four) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = 1'b1;
            end else if (stat.even) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = 1'b0;
            end else begin
               rsp_valid_in = 1'b0;
            end
         end
         tdpt_pkg::ST_BOUND: begin
            if (stat.sq_gt_n) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
            end
         end
         tdpt_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         tdpt_pkg::ST_TEST: begin
            if (stat.rem_zero) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = 1'b0;
            end else begin
               cmd.next_div = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   // State and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdpt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_prime_ff <= rsp_prime_in;
   end

   assign busy         = (state_ff != tdpt_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_prime_ff;

endmodule

>>> rtl/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by trial division
// Reports whether a signed value is prime, trying 2 and then odd divisors
// up to the square root with a bit-serial remainder unit.
// ----------------------------------------------------------------------------
//   channel   ports                    handshake
//   request   req_value                start high while busy low
//   result    rsp_is_prime             rsp_valid strobe, one cycle
//
// Negative, zero, one, two, three and even values are settled by the screen
// alone. Other odd values loop over odd divisors until one divides the value
// or the square passes it. Each divisor costs one bound check, MAG_WIDTH (31)
// remainder steps and one test. Worst case is about 23170 divisors.
// Synchronous reset returns the controller to idle and drops any strobe.
// The receiver cannot stall: the result strobe lasts one cycle, and busy
// is already low in that cycle.
// ----------------------------------------------------------------------------
module trial_division_prime_test (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [tdpt_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                    rsp_valid,
   output logic                                    rsp_is_prime
);

   tdpt_pkg::tdpt_cmd_type  cmd;
   tdpt_pkg::tdpt_stat_type stat;

   tdpt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .stat         (stat),
      .cmd          (cmd),
      .rsp_valid    (rsp_valid),
      .rsp_is_prime (rsp_is_prime)
   );

   tdpt_datapath u_datapath (
      .clock     (clock),
      .req_value (req_value),
      .cmd       (cmd),
      .stat      (stat)
   );

   // An accepted request makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // A result follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without work in progress");

   // The result strobe lasts one cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held");

   // Datapath commands stay exclusive and loads happen only when idle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd) && (!cmd.load || !busy))
      else $error("conflicting datapath commands");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the trial-division prime test
// Sends signed values through the start/busy command port. Each value gets a
// prime/not-prime verdict from a local model, and every rsp_valid strobe is
// compared with the oldest open verdict. The directed values cover the sign
// edge, zero, one, two, three, squares of odd primes and the top of the range.
// The random values are mostly negative, small or medium numbers, large
// multiples of 2 or a small odd prime and odd near-squares, so the run stays short.
// ----------------------------------------------------------------------------

// Predict and check verdicts in request order
class prime_verdict_board;
   bit     open_verdicts[$];
   int     requests_seen;
   int     primes_seen;
   int     negatives_seen;
   int     verdicts_checked;
   int     failures;

   // Work out the verdict for one accepted request
   function void note_request(logic signed [tdpt_pkg::VALUE_WIDTH-1:0] value);
      logic [63:0] n;
      logic [63:0] d;
      bit          verdict;
      requests_seen++;
      if (value < 0) negatives_seen++;
      n       = 64'(value);
      verdict = 1'b0;
      if (value > 1) begin
         if (n < 4) begin
            verdict = 1'b1;
         end else if (n[0]) begin
            verdict = 1'b1;
            for (d = 3; d * d <= n; d += 2) begin
               if (n % d == 0) begin
                  verdict = 1'b0;
                  break;
               end
            end
         end
      end
      if (verdict) primes_seen++;
      open_verdicts.push_back(verdict);
   endfunction

   // Compare one strobed verdict with the oldest open one
   function void check_result(logic actual);
      bit wanted;
      if (open_verdicts.size() == 0) begin
         $display("%0t: unexpected verdict, expected none, actual %b", $time, actual);
         failures++;
      end else begin
         wanted = open_verdicts.pop_front();
         verdicts_checked++;
         if (actual !== wanted) begin
            $display("%0t: is_prime mismatch, expected %b, actual %b",
                     $time, wanted, actual);
            failures++;
         end
      end
   endfunction

   function int pending();
      return open_verdicts.size();
   endfunction
endclass

module tb_top;

   logic                                     clock;
   logic                                     reset     = 1'b1;
   logic                                     start     = 1'b0;
   logic signed [tdpt_pkg::VALUE_WIDTH-1:0]  req_value = '0;
   logic                                     busy;
   logic                                     rsp_valid;
   logic                                     rsp_is_prime;

   prime_verdict_board board = new();

   // Odd primes used to build large composites that fail fast
   int unsigned small_odd_primes[6] = '{3, 5, 7, 11, 13, 17};

   // Directed values: sign edge, tiny values, odd squares, range top
   logic signed [tdpt_pkg::VALUE_WIDTH-1:0] directed_values[$] = '{
      32'sh80000000, -32'sd7, -32'sd1, 32'sd0, 32'sd1, 32'sd2, 32'sd3,
      32'sd4, 32'sd5, 32'sd9, 32'sd25, 32'sd49, 32'sd97, 32'sd1369,
      32'sd1371, 32'sd65521, 32'sd65535, 32'sd1048573, 32'sh7FFFFFFE,
      32'sh7FFFFFFD, 32'sh7FFFFFFF
   };

   int burst_left = 0;

   trial_division_prime_test u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_is_prime (rsp_is_prime)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #200_000_000;
      $display("timeout with %0d verdicts still open", board.pending());
      $display("tb_top: FAIL");
      $finish;
   end

   // Check every verdict strobe at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_result(rsp_is_prime);
      end
   end

   // Hold start high with the value until the block takes the request
   task automatic send_request(input logic signed [tdpt_pkg::VALUE_WIDTH-1:0] value);
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
      board.note_request(value);
   endtask

   // Drop start between bursts for a random number of cycles
   task automatic sender_pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 9);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Idle the sender until every open verdict has come back
   task automatic drain_verdicts();
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Pick a random value, weighted toward cheap cases
   function automatic logic signed [tdpt_pkg::VALUE_WIDTH-1:0] random_value();
      logic [31:0] r;
      int unsigned p;
      int unsigned d;
      r = $urandom();
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4: begin
            r[31] = 1'b1;
         end
         5, 6, 7, 8, 9, 10: begin
            r = $urandom_range(0, 4095);
         end
         11, 12, 13: begin
            r = $urandom_range(0, 1 << 20);
         end
         14, 15, 16, 17: begin
            // large positive multiple of a small odd prime, or even
            r[31] = 1'b0;
            p     = ($urandom_range(0, 4) == 0) ? 2 : small_odd_primes[$urandom_range(0, 5)];
            r     = r - (r % p);
         end
         default: begin
            // odd square or near-square, right at the divisor bound
            d = 2 * $urandom_range(1, 127) + 1;
            r = ($urandom_range(0, 1) == 0) ? d * d : d * (d + 2);
         end
      endcase
      return r;
   endfunction

   initial begin
      int n_random;
      n_random = 80;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed values back to back
      foreach (directed_values[i]) begin
         send_request(directed_values[i]);
      end
      drain_verdicts();

      // Random values in bursts, with one full drain halfway
      for (int i = 0; i < n_random; i++) begin
         sender_pace();
         send_request(random_value());
         if (i == n_random / 2) begin
            drain_verdicts();
         end
      end

      drain_verdicts();
      repeat (8) @(posedge clock);

      $display("covered %0d requests (%0d negative, %0d prime), %0d verdicts checked",
               board.requests_seen, board.negatives_seen, board.primes_seen,
               board.verdicts_checked);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/tdpt_pkg.sv
rtl/tdpt_datapath.sv
rtl/tdpt_ctrl.sv
rtl/trial_division_prime_test.sv
dv/tb_top.sv
